// ===== rtl/rv32i_instruction_execute_unit_macros.svh =====
// Assertion macros shared by the execute unit.
`ifndef RV32I_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define RV32I_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define RIE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define RIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rie_pkg.sv =====
package rie_pkg;

   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_FENCE  = 7'h0F;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
   localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
   localparam logic [31:0] UPPER_MASK  = 32'hFFFF_F000;
   localparam logic [6:0]  ALT_FUNCT7  = 7'h20;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRAP      = 3'd1;
   localparam logic [2:0] ST_ILLEGAL   = 3'd2;
   localparam logic [2:0] ST_UNEXP     = 3'd3;
   localparam logic [2:0] ST_PENDING   = 3'd4;

   localparam logic KIND_EXEC = 1'b0;

   typedef struct packed {
      logic        kind;
      logic [31:0] instruction;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [1:0]  mem_op;
      logic [31:0] mem_addr;
      logic [31:0] mem_wdata;
      logic [1:0]  mem_size;
      logic        rd_write;
      logic [4:0]  rd_index;
      logic [31:0] rd_value;
      logic [2:0]  status;
   } rsp_type;

   // Architectural update from the execute logic, applied on transfer.
   typedef struct packed {
      logic        pc_load;
      logic [31:0] pc_value;
      logic        load_set;
      logic        load_clear;
      logic [4:0]  load_dest;
      logic [1:0]  load_width;
      logic        load_sign;
   } upd_type;

   // Pending load bookkeeping.
   typedef struct packed {
      logic       waiting;
      logic [4:0] dest;
      logic [1:0] width;
      logic       sign;
   } ld_type;

   function automatic logic [31:0] sext12(input logic [11:0] v);
      return {{20{v[11]}}, v};
   endfunction

endpackage

// ===== rtl/rv32i_instruction_execute_unit.sv =====
// Channel  | Ports                          | Transfer when
// request  | req_valid, req_stall, req_data | req_valid && !req_stall
// response | rsp_valid, rsp_stall, rsp_data | rsp_valid && !rsp_stall
// config   | csr_write, csr_data            | csr_write
// One item per cycle unless the response stalls; the result appears in the cycle
// after its transfer via the single decode/ALU pass, register file to result register.
// The next item reads state updated by the previous one, so no hazard stall.
// Synchronous reset clears the register file, pc and load tracking.
// A stalled response holds its register; the request side stalls only then.
module rv32i_instruction_execute_unit
   import rie_pkg::*;
#(
   parameter int REGISTER_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [31:0] csr_data
);

   `include "rv32i_instruction_execute_unit_macros.svh"

   logic        pc_load;
   logic [31:0] pc_ff, pc_in;
   ld_type      ld_ff, ld_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   upd_type     upd;
   logic [4:0]  rs1_addr, rs2_addr;
   logic [31:0] rs1_data, rs2_data;
   logic        xfer;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign xfer = req_valid && !req_stall;

   rie_regfile #(.REGISTER_COUNT(REGISTER_COUNT)) u_regfile (
      .clock, .reset,
      .rs1_addr, .rs2_addr, .rs1_data, .rs2_data,
      .wr_en(xfer && rsp_in.rd_write),
      .wr_addr(rsp_in.rd_index),
      .wr_data(rsp_in.rd_value)
   );

   rie_exec #(.REGISTER_COUNT(REGISTER_COUNT)) u_exec (
      .req(req_data), .pc(pc_ff), .ld(ld_ff),
      .rs1_data, .rs2_data, .rs1_addr, .rs2_addr,
      .rsp(rsp_in), .upd
   );

   assign pc_load = xfer && upd.pc_load;

   always_comb begin
      pc_in = pc_ff;
      if (csr_write) pc_in = csr_data;
      else if (pc_load) pc_in = upd.pc_value;
      ld_in = ld_ff;
      if (xfer && upd.load_set) begin
         ld_in.waiting = 1'b1;
         ld_in.dest = upd.load_dest;
         ld_in.width = upd.load_width;
         ld_in.sign = upd.load_sign;
      end else if (xfer && upd.load_clear) begin
         ld_in.waiting = 1'b0;
      end
      rsp_valid_in = xfer || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         ld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         ld_ff <= ld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // advance the result register on every transfer
   always_ff @(posedge clock) begin
      if (xfer) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `RIE_ASSERT_NEXT(a_load_sets_wait, clock, reset,
      xfer && rsp_in.mem_op == MEM_READ, ld_ff.waiting, "load did not mark pending")
   `RIE_ASSERT_IMP(a_pending_no_write, clock, reset,
      rsp_valid && rsp_data.status == ST_PENDING, !rsp_data.rd_write, "pending wrote rd")
   `RIE_ASSERT_NEXT(a_hold_on_stall, clock, reset,
      rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result dropped on stall")

endmodule

// ===== rtl/rie_regfile.sv =====
module rie_regfile
   import rie_pkg::*;
#(
   parameter int REGISTER_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [4:0]  rs1_addr,
   input  logic [4:0]  rs2_addr,
   output logic [31:0] rs1_data,
   output logic [31:0] rs2_data,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);

   // Small flop array; reset clears it at once, x0 never written.
   logic [31:0] regs_ff [REGISTER_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REGISTER_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (wr_en && wr_addr != 5'd0 && 32'(wr_addr) < REGISTER_COUNT) begin
         regs_ff[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      rs1_data = '0;
      rs2_data = '0;
      for (int i = 1; i < REGISTER_COUNT; i++) begin
         if (32'(rs1_addr) == i) rs1_data = regs_ff[i];
         if (32'(rs2_addr) == i) rs2_data = regs_ff[i];
      end
   end

endmodule

// ===== rtl/rie_exec.sv =====
module rie_exec
   import rie_pkg::*;
#(
   parameter int REGISTER_COUNT = 32
) (
   input  req_type     req,
   input  logic [31:0] pc,
   input  ld_type      ld,
   input  logic [31:0] rs1_data,
   input  logic [31:0] rs2_data,
   output logic [4:0]  rs1_addr,
   output logic [4:0]  rs2_addr,
   output rsp_type     rsp,
   output upd_type     upd
);

   logic [31:0] ins, seq, a, b, imm_i, imm_s, imm_b, imm_j, y, v, sra_v, d;
   logic [6:0]  op, f7;
   logic [4:0]  rd, rs1, rs2, sh;
   logic [2:0]  f3;
   logic        rd_ok, rs1_ok, rs2_ok, is_reg, take, lts, ltu, alt_ok, wr;
   logic [1:0]  mop, msz;
   logic [31:0] maddr, npc;
   logic [2:0]  st;

   assign ins = req.instruction;
   assign op  = ins[6:0];
   assign rd  = ins[11:7];
   assign f3  = ins[14:12];
   assign rs1 = ins[19:15];
   assign rs2 = ins[24:20];
   assign f7  = ins[31:25];
   assign rs1_addr = rs1;
   assign rs2_addr = rs2;
   assign a = rs1_data;
   assign b = rs2_data;
   assign seq = pc + 32'd4;
   assign imm_i = sext12(ins[31:20]);
   assign imm_s = sext12({ins[31:25], ins[11:7]});
   assign imm_b = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
   assign imm_j = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
   assign rd_ok  = 32'(rd) < REGISTER_COUNT;
   assign rs1_ok = 32'(rs1) < REGISTER_COUNT;
   assign rs2_ok = 32'(rs2) < REGISTER_COUNT;
   assign is_reg = (op == OP_REG);
   assign y  = is_reg ? b : imm_i;
   assign sh = y[4:0];
   assign lts = $signed(a) < $signed(y);
   assign ltu = a < y;
   assign sra_v = 32'($signed(a) >>> sh);
   assign alt_ok = (f3 == F3_SR) || (is_reg && f3 == F3_ADD);
   assign d = req.load_data;

   always_comb begin
      unique case (f3)
         F3_BEQ:  take = (a == b);
         F3_BNE:  take = (a != b);
         F3_BLT:  take = $signed(a) < $signed(b);
         F3_BGE:  take = !($signed(a) < $signed(b));
         F3_BLTU: take = a < b;
         default: take = a >= b;
      endcase
   end

   always_comb begin
      npc = seq;
      mop = MEM_NONE;
      maddr = '0;
      msz = SIZE_BYTE;
      wr = 1'b0;
      v = '0;
      st = ST_OK;
      upd = '0;
      upd.pc_load = 1'b1;
      if (req.kind != KIND_EXEC) begin
         npc = pc;
         upd.pc_load = 1'b0;
         if (!ld.waiting) begin
            st = ST_UNEXP;
         end else begin
            upd.load_clear = 1'b1;
            wr = 1'b1;
            case (ld.width)
               SIZE_BYTE: v = ld.sign ? {{24{d[7]}}, d[7:0]} : {24'd0, d[7:0]};
               SIZE_HALF: v = ld.sign ? {{16{d[15]}}, d[15:0]} : {16'd0, d[15:0]};
               default:   v = d;
            endcase
         end
      end else if (ld.waiting) begin
         npc = pc;
         upd.pc_load = 1'b0;
         st = ST_PENDING;
      end else begin
         unique case (op)
            OP_LUI, OP_AUIPC, OP_JAL: begin
               if (!rd_ok) st = ST_ILLEGAL;
               else begin
                  wr = 1'b1;
                  if (op == OP_LUI) v = ins & UPPER_MASK;
                  else if (op == OP_AUIPC) v = pc + (ins & UPPER_MASK);
                  else begin
                     v = seq;
                     npc = pc + imm_j;
                  end
               end
            end
            OP_JALR: begin
               if (f3 != 3'd0 || !rd_ok || !rs1_ok) st = ST_ILLEGAL;
               else begin
                  npc = (a + imm_i) & ~32'd1;
                  wr = 1'b1;
                  v = seq;
               end
            end
            OP_BRANCH: begin
               if (f3 == 3'd2 || f3 == 3'd3 || !rs1_ok || !rs2_ok) st = ST_ILLEGAL;
               else if (take) npc = pc + imm_b;
            end
            OP_LOAD: begin
               if (f3 == 3'd3 || f3 > 3'd5 || !rd_ok || !rs1_ok) st = ST_ILLEGAL;
               else begin
                  mop = MEM_READ;
                  maddr = a + imm_i;
                  msz = f3[1:0];
                  upd.load_set = 1'b1;
                  upd.load_dest = rd;
                  upd.load_width = f3[1:0];
                  upd.load_sign = !f3[2];
               end
            end
            OP_STORE: begin
               if (f3 > 3'd2 || !rs1_ok || !rs2_ok) st = ST_ILLEGAL;
               else begin
                  mop = MEM_WRITE;
                  maddr = a + imm_s;
                  msz = f3[1:0];
               end
            end
            OP_IMM, OP_REG: begin
               if (!rd_ok || !rs1_ok || (is_reg && !rs2_ok)) st = ST_ILLEGAL;
               else if ((is_reg || f3 == F3_SLL || f3 == F3_SR) &&
                        !(f7 == 7'd0 || (f7 == ALT_FUNCT7 && alt_ok))) st = ST_ILLEGAL;
               else begin
                  wr = 1'b1;
                  case (f3)
                     F3_ADD:  v = (is_reg && f7 == ALT_FUNCT7) ? a - y : a + y;
                     F3_SLL:  v = a << sh;
                     F3_SLT:  v = {31'd0, lts};
                     F3_SLTU: v = {31'd0, ltu};
                     F3_XOR:  v = a ^ y;
                     F3_SR:   v = (f7 == ALT_FUNCT7) ? sra_v : a >> sh;
                     F3_OR:   v = a | y;
                     default: v = a & y;
                  endcase
               end
            end
            OP_FENCE: ;
            OP_SYSTEM: begin
               if (ins == INSN_ECALL || ins == INSN_EBREAK) st = ST_TRAP;
               else st = ST_ILLEGAL;
            end
            default: st = ST_ILLEGAL;
         endcase
      end
      if (st == ST_ILLEGAL) begin
         npc = seq;
         mop = MEM_NONE;
         wr = 1'b0;
         upd.load_set = 1'b0;
      end
      upd.pc_value = npc;
   end

   logic [4:0] wr_idx;
   logic       w;
   assign wr_idx = (req.kind != KIND_EXEC) ? ld.dest : rd;
   assign w = wr && wr_idx != 5'd0;

   always_comb begin
      rsp.next_pc   = npc;
      rsp.mem_op    = mop;
      rsp.mem_addr  = (mop != MEM_NONE) ? maddr : '0;
      rsp.mem_wdata = (mop == MEM_WRITE) ? b : '0;
      rsp.mem_size  = (mop != MEM_NONE) ? msz : SIZE_BYTE;
      rsp.rd_write  = w;
      rsp.rd_index  = w ? wr_idx : '0;
      rsp.rd_value  = w ? v : '0;
      rsp.status    = st;
   end

endmodule

// ===== sim/rv32i_instruction_execute_unit_checker.sv =====
`timescale 1ns / 100ps

module rv32i_instruction_execute_unit_checker
   import rie_pkg::*;
#(
   parameter int REGISTER_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending_count
);

   logic [31:0] regs [32];
   logic [31:0] pc;
   ld_type      ld;
   rsp_type     expected_rsp [$];

   assign pending_count = expected_rsp.size();

   function automatic logic [31:0] reg_read(input logic [4:0] idx);
      return idx == 5'd0 ? 32'd0 : regs[idx];
   endfunction

   function automatic logic idx_ok(input logic [4:0] idx);
      return int'(idx) < REGISTER_COUNT;
   endfunction

   // Advance the shadow core by one item and return its result.
   function automatic rsp_type execute_item(input req_type r);
      rsp_type     o;
      logic [31:0] ins, a, b, imm, seq, v, y, off;
      logic [6:0]  op, f7;
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3;
      logic        wr, bad, take, isreg;
      o = '0;
      wr = 1'b0;
      v = 32'd0;
      bad = 1'b0;
      seq = pc + 32'd4;
      ins = r.instruction;
      op = ins[6:0];
      rd = ins[11:7];
      f3 = ins[14:12];
      rs1 = ins[19:15];
      rs2 = ins[24:20];
      f7 = ins[31:25];
      a = reg_read(rs1);
      b = reg_read(rs2);
      imm = {{20{ins[31]}}, ins[31:20]};
      o.next_pc = pc;
      if (r.kind != KIND_EXEC) begin
         if (!ld.waiting) begin
            o.status = ST_UNEXP;
         end else begin
            case (ld.width)
               SIZE_BYTE: v = ld.sign ? {{24{r.load_data[7]}}, r.load_data[7:0]}
                                      : {24'd0, r.load_data[7:0]};
               SIZE_HALF: v = ld.sign ? {{16{r.load_data[15]}}, r.load_data[15:0]}
                                      : {16'd0, r.load_data[15:0]};
               default:   v = r.load_data;
            endcase
            ld.waiting = 1'b0;
            rd = ld.dest;
            wr = 1'b1;
         end
      end else if (ld.waiting) begin
         o.status = ST_PENDING;
      end else begin
         o.next_pc = seq;
         case (op)
            OP_LUI, OP_AUIPC, OP_JAL: begin
               if (!idx_ok(rd)) bad = 1'b1;
               else begin
                  wr = 1'b1;
                  if (op == OP_LUI) v = ins & UPPER_MASK;
                  else if (op == OP_AUIPC) v = pc + (ins & UPPER_MASK);
                  else begin
                     v = seq;
                     off = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                     o.next_pc = pc + off;
                  end
               end
            end
            OP_JALR: begin
               if (f3 != 3'd0 || !idx_ok(rd) || !idx_ok(rs1)) bad = 1'b1;
               else begin
                  o.next_pc = (a + imm) & ~32'd1;
                  wr = 1'b1;
                  v = seq;
               end
            end
            OP_BRANCH: begin
               if (f3 == 3'd2 || f3 == 3'd3 || !idx_ok(rs1) || !idx_ok(rs2)) bad = 1'b1;
               else begin
                  case (f3)
                     F3_BEQ:  take = a == b;
                     F3_BNE:  take = a != b;
                     F3_BLT:  take = $signed(a) < $signed(b);
                     F3_BGE:  take = $signed(a) >= $signed(b);
                     F3_BLTU: take = a < b;
                     default: take = a >= b;
                  endcase
                  off = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                  if (take) o.next_pc = pc + off;
               end
            end
            OP_LOAD: begin
               if (f3 == 3'd3 || f3 > 3'd5 || !idx_ok(rd) || !idx_ok(rs1)) bad = 1'b1;
               else begin
                  ld.waiting = 1'b1;
                  ld.dest = rd;
                  ld.width = f3[1:0];
                  ld.sign = f3 < 3'd4;
                  o.mem_op = MEM_READ;
                  o.mem_addr = a + imm;
                  o.mem_size = f3[1:0];
               end
            end
            OP_STORE: begin
               if (f3 > 3'd2 || !idx_ok(rs1) || !idx_ok(rs2)) bad = 1'b1;
               else begin
                  o.mem_op = MEM_WRITE;
                  o.mem_addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                  o.mem_wdata = b;
                  o.mem_size = f3[1:0];
               end
            end
            OP_IMM, OP_REG: begin
               isreg = op == OP_REG;
               y = isreg ? b : imm;
               if (!idx_ok(rd) || !idx_ok(rs1) || (isreg && !idx_ok(rs2))) bad = 1'b1;
               else if ((isreg || f3 == F3_SLL || f3 == F3_SR) && !(f7 == 7'd0 ||
                        (f7 == ALT_FUNCT7 && (f3 == F3_SR || (isreg && f3 == F3_ADD)))))
                  bad = 1'b1;
               else begin
                  wr = 1'b1;
                  case (f3)
                     F3_ADD:  v = (isreg && f7 == ALT_FUNCT7) ? a - y : a + y;
                     F3_SLL:  v = a << y[4:0];
                     F3_SLT:  v = {31'd0, $signed(a) < $signed(y)};
                     F3_SLTU: v = {31'd0, a < y};
                     F3_XOR:  v = a ^ y;
                     F3_SR:   v = (f7 == ALT_FUNCT7) ? 32'($signed(a) >>> y[4:0])
                                                     : a >> y[4:0];
                     F3_OR:   v = a | y;
                     default: v = a & y;
                  endcase
               end
            end
            OP_FENCE: ;
            OP_SYSTEM: begin
               if (ins == INSN_ECALL || ins == INSN_EBREAK) o.status = ST_TRAP;
               else bad = 1'b1;
            end
            default: bad = 1'b1;
         endcase
         if (bad) begin
            o = '0;
            o.next_pc = seq;
            o.status = ST_ILLEGAL;
            wr = 1'b0;
         end
      end
      if (wr && rd != 5'd0) begin
         o.rd_write = 1'b1;
         o.rd_index = rd;
         o.rd_value = v;
         regs[rd] = v;
      end
      pc = o.next_pc;
      return o;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         foreach (regs[i]) regs[i] = 32'd0;
         pc = 32'd0;
         ld = '0;
         fail_count = 0;
         expected_rsp.delete();
      end else begin
         if (csr_write) pc = csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("response transfer with nothing expected");
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               compare_field("next_pc", e.next_pc, rsp_data.next_pc);
               compare_field("mem_op", 32'(e.mem_op), 32'(rsp_data.mem_op));
               compare_field("mem_addr", e.mem_addr, rsp_data.mem_addr);
               compare_field("mem_wdata", e.mem_wdata, rsp_data.mem_wdata);
               compare_field("mem_size", 32'(e.mem_size), 32'(rsp_data.mem_size));
               compare_field("rd_write", 32'(e.rd_write), 32'(rsp_data.rd_write));
               compare_field("rd_index", 32'(e.rd_index), 32'(rsp_data.rd_index));
               compare_field("rd_value", e.rd_value, rsp_data.rd_value);
               compare_field("status", 32'(e.status), 32'(rsp_data.status));
            end
         end
         if (req_valid && !req_stall) expected_rsp.push_back(execute_item(req_data));
      end
   end

endmodule

// ===== sim/rv32i_instruction_execute_unit_tb.sv =====
`timescale 1ns / 100ps

module rv32i_instruction_execute_unit_tb;
   import rie_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write;
   logic [31:0] csr_data;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          cycle_count = 0;
   logic        load_open;

   localparam int CYCLE_LIMIT = 400000;

   rv32i_instruction_execute_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   rv32i_instruction_execute_unit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** rv32i_instruction_execute_unit: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Leave valid high after the transfer; the next call or an idle drops it.
   task automatic send_item(input logic kind, input logic [31:0] ins, input logic [31:0] ld);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{kind: kind, instruction: ins, load_data: ld};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_exec(input logic [31:0] ins);
      send_item(KIND_EXEC, ins, $urandom());
   endtask

   task automatic send_load_data(input logic [31:0] d);
      send_item(~KIND_EXEC, $urandom(), d);
   endtask

   // Drain, then write the start address while the pipe is quiet.
   task automatic write_start_pc(input logic [31:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [31:0] r_word(input logic [6:0] op, input logic [2:0] f3,
                                          input logic [6:0] f7);
      logic [31:0] w;
      w = $urandom();
      w[6:0] = op;
      w[14:12] = f3;
      w[31:25] = f7;
      return w;
   endfunction

   // Mostly legal instructions with random operands, some raw noise.
   function automatic logic [31:0] random_instruction();
      logic [31:0] w;
      logic [6:0]  ops [11];
      int          pick;
      ops = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH, OP_LOAD, OP_STORE,
              OP_IMM, OP_REG, OP_FENCE, OP_SYSTEM};
      pick = $urandom_range(99);
      w = $urandom();
      if (pick < 8) return w;
      if (pick < 10) return $urandom_range(1) ? INSN_ECALL : INSN_EBREAK;
      w[6:0] = ops[$urandom_range(10)];
      if (w[6:0] == OP_IMM || w[6:0] == OP_REG) begin
         if ($urandom_range(9) != 0) w[31:25] = $urandom_range(1) ? ALT_FUNCT7 : 7'd0;
         if (w[6:0] == OP_IMM && w[14:12] == F3_SR && $urandom_range(1)) w[31:25] = 7'd0;
      end
      if (w[6:0] == OP_JALR && $urandom_range(3) != 0) w[14:12] = 3'd0;
      return w;
   endfunction

   task automatic run_random(input int count);
      logic [31:0] w;
      for (int i = 0; i < count; i++) begin
         if (load_open && $urandom_range(9) != 0) begin
            send_load_data($urandom());
            load_open = 1'b0;
         end else begin
            w = random_instruction();
            send_exec(w);
            if (!load_open && w[6:0] == OP_LOAD && w[14:12] != 3'd3 && w[14:12] <= 3'd5)
               load_open = 1'b1;
            else if ($urandom_range(29) == 0) send_load_data($urandom());
         end
      end
      // Close a waiting load so the pipe drains clean.
      send_load_data($urandom());
      load_open = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_data = 32'd0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_open = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: seed registers, every opcode, edge cases
      send_exec(r_word(OP_LUI, 3'd0, 7'h7F) | 32'h0000_0080);
      send_exec({12'h7FF, 5'd0, F3_ADD, 5'd2, OP_IMM});
      send_exec({12'h800, 5'd0, F3_ADD, 5'd3, OP_IMM});
      send_exec({7'h00, 5'd3, 5'd1, F3_ADD, 5'd0, OP_REG});
      send_exec({ALT_FUNCT7, 5'd3, 5'd2, F3_ADD, 5'd4, OP_REG});
      send_exec({ALT_FUNCT7, 5'd31, 5'd3, F3_SR, 5'd5, OP_IMM});
      send_exec({7'h00, 5'd3, 5'd3, F3_SLT, 5'd6, OP_REG});
      send_exec({7'h00, 5'd2, 5'd3, F3_BLT, 5'b01000, OP_BRANCH});
      send_exec({7'h00, 5'd2, 5'd3, F3_BGEU, 5'b01000, OP_BRANCH});
      send_exec({7'h01, 5'd3, 5'd1, 3'd2, 5'd7, OP_STORE});
      send_exec({12'hFFF, 5'd3, 3'd4, 5'd8, OP_LOAD});
      send_exec(INSN_ECALL);
      send_load_data(32'hFFFF_FF80);
      send_load_data(32'hFFFF_FFFF);
      send_exec({12'h000, 5'd3, 3'd0, 5'd0, OP_LOAD});
      send_load_data(32'h0000_8000);
      send_exec(INSN_EBREAK);
      send_exec({20'hFFFFF, 5'd1, OP_JAL});
      send_exec({12'h001, 5'd3, 3'd0, 5'd9, OP_JALR});
      send_exec({20'h80000, 5'd10, OP_AUIPC});
      send_exec({17'd0, 3'd5, 5'd0, OP_FENCE});
      send_exec(32'hFFFF_FFFF);
      send_exec({ALT_FUNCT7, 5'd1, 5'd1, F3_XOR, 5'd1, OP_REG});

      write_start_pc(32'hFFFF_FFFC);
      send_idle_pct = 20;
      recv_idle_pct = 51;
      run_random(575);
      write_start_pc(32'h0000_0000);
      send_idle_pct = 51;
      recv_idle_pct = 20;
      run_random(575);
      write_start_pc($urandom());
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(575);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (fail_count == 0) $display("** rv32i_instruction_execute_unit: PASSED **");
      else $display("** rv32i_instruction_execute_unit: FAILED **");
      $finish;
   end

endmodule
